// ===== design/bts_pkg.sv =====
`timescale 1ns / 1ps

package bts_pkg;

    // Field widths fixed by the item formats.
    localparam int COORD_BITS_DEF = 16;
    localparam int CYCLE_W        = 32;
    localparam int HEIGHT_W       = 12;
    localparam int STEP_W         = 16;
    localparam int SCORE_W        = 12;
    localparam int CASE_W         = 2;
    localparam int USER_OUT_W     = CASE_W + 1;

    // Shared multiplier: a coordinate delta, elapsed cycles (31 bits) or a reach (26 bits) on port A,
    // max step (16 bits), a coordinate delta or a reach (26 bits) on port B.
    localparam int EL_W    = 31;
    localparam int REACH_W = 26;
    localparam int MUL_A_W = 31;
    localparam int MUL_B_W = 26;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // A reach above this passes the gate whenever the elapsed cycle count is positive.
    localparam logic [PROD_W-1:0] REACH_CAP = PROD_W'(1) << (REACH_W - 1);

    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(2000);

    // Scores count in units of 0.05.
    localparam logic signed [SCORE_W-1:0] SCORE_ONE       = SCORE_W'(20);
    localparam logic signed [SCORE_W-1:0] SCORE_TENTH     = SCORE_W'(2);
    localparam logic signed [SCORE_W-1:0] SCORE_TWENTIETH = SCORE_W'(1);
    localparam logic signed [SCORE_W-1:0] SCORE_MAX       = SCORE_W'(2047);
    localparam logic signed [SCORE_W-1:0] SCORE_MIN       = SCORE_W'(-2048);

    // Track case codes on the result item.
    localparam logic [CASE_W-1:0] CASE_CONF    = 2'd0;
    localparam logic [CASE_W-1:0] CASE_TENT    = 2'd1;
    localparam logic [CASE_W-1:0] CASE_RESTART = 2'd2;

    typedef enum logic [2:0] {
        MUL_NONE  = 3'd0,
        MUL_DX    = 3'd1,
        MUL_DY    = 3'd2,
        MUL_REACH = 3'd3,
        MUL_RSQ   = 3'd4
    } t_mul_op;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic    load_in;
        t_mul_op mul_op;
        logic    sum_cand;
        logic    sum_tent;
        logic    gate_conf;
        logic    gate_tent;
        logic    finish;
    } t_cmd;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic last;
        logic pass;
        logic out_free;
    } t_status;

endpackage

// ===== design/ball_track_selector_unit.sv =====
`timescale 1ns / 1ps

// Ball track selector.
// The slave stream carries one ball detection per item; tlast marks the last
// detection of a vision frame. The master stream carries one item per frame:
// the chosen ball position, the track case and the promotion flag.
// The max_step register (greatest travel per cycle, mm) is written with
// i_cfg_we / i_cfg_wdata; the user must write it only while the block is idle,
// as the block does not enforce this; reset loads 2000.
// A detection that is not the last of its frame passes the two squares of the
// shared multiplier and the distance compare before the next is taken. For the
// last detection the confirmed track is gated, and the tentative track too when
// that gate fails; the result is valid in the cycle after the finish state. All
// squaring and reach products go through one registered multiplier, one product per cycle.
// Reset clears both tracks, their scores and the frame's best candidate.
// The result sits in an output register; the block keeps taking detections
// while it waits, and only the end of the next frame stalls until the result
// has been taken.
module ball_track_selector_unit #(
    parameter int COORD_BITS = bts_pkg::COORD_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration write of max_step.
    input  logic                             i_cfg_we,
    input  logic [bts_pkg::STEP_W-1:0]       i_cfg_wdata,
    // Detection stream.
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // Fields from bit 0: frame_cycle, cand_x, cand_y, cand_height, zero fill.
    input  logic [((bts_pkg::CYCLE_W + 2 * COORD_BITS + bts_pkg::HEIGHT_W + 7) / 8) * 8 - 1:0]
                                             i_s_axis_tdata,
    input  logic                             i_s_axis_tlast,
    // Result stream.
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // Fields from bit 0: ball_x, ball_y, ball_height, zero fill.
    output logic [((2 * COORD_BITS + bts_pkg::HEIGHT_W + 7) / 8) * 8 - 1:0]
                                             o_m_axis_tdata,
    // Fields from bit 0: track_case, switched.
    output logic [bts_pkg::USER_OUT_W-1:0]   o_m_axis_tuser
);

    localparam int OUT_W = ((2 * COORD_BITS + bts_pkg::HEIGHT_W + 7) / 8) * 8;
    localparam int X_LO  = bts_pkg::CYCLE_W;
    localparam int Y_LO  = X_LO + COORD_BITS;
    localparam int H_LO  = Y_LO + COORD_BITS;

    bts_pkg::t_cmd                    w_cmd;
    bts_pkg::t_status                 w_status;
    logic signed [COORD_BITS-1:0]     w_ball_x;
    logic signed [COORD_BITS-1:0]     w_ball_y;
    logic [bts_pkg::HEIGHT_W-1:0]     w_ball_h;
    logic [bts_pkg::CASE_W-1:0]       w_case;
    logic                             w_switched;

    // Sequencer.
    bts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Datapath with the shared multiplier and track state.
    bts_dp #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (w_cmd),
        .i_cyc       (i_s_axis_tdata[bts_pkg::CYCLE_W-1:0]),
        .i_cx        (i_s_axis_tdata[X_LO +: COORD_BITS]),
        .i_cy        (i_s_axis_tdata[Y_LO +: COORD_BITS]),
        .i_ch        (i_s_axis_tdata[H_LO +: bts_pkg::HEIGHT_W]),
        .i_last      (i_s_axis_tlast),
        .i_out_ready (i_m_axis_tready),
        .o_status    (w_status),
        .o_out_valid (o_m_axis_tvalid),
        .o_ball_x    (w_ball_x),
        .o_ball_y    (w_ball_y),
        .o_ball_h    (w_ball_h),
        .o_case      (w_case),
        .o_switched  (w_switched)
    );

    // Pack the result item.
    assign o_m_axis_tdata = OUT_W'({w_ball_h, w_ball_y, w_ball_x});
    assign o_m_axis_tuser = {w_switched, w_case};

    // A detection that does not end its frame frees the input again after its squares and distance sum.
    a_mid_frame_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && !i_s_axis_tlast) |-> ##4 o_s_axis_tready)
        else $error("mid-frame detection did not complete in 4 cycles");

    // A new result only appears at the end of frame processing.
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(!o_s_axis_tready))
        else $error("result appeared while the block was idle");

    // A promotion never follows a confirmed-track continuation.
    a_switch_case: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[bts_pkg::CASE_W])
            |-> (o_m_axis_tuser[bts_pkg::CASE_W-1:0] != bts_pkg::CASE_CONF))
        else $error("promotion reported with confirmed track continued");

endmodule

// ===== design/bts_ctrl.sv =====
`timescale 1ns / 1ps

module bts_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  bts_pkg::t_status i_status,
    output bts_pkg::t_cmd    o_cmd
);

    typedef enum logic [13:0] {
        S_IDLE     = 14'h0001,
        S_C_SQX    = 14'h0002,
        S_C_SQY    = 14'h0004,
        S_C_SUM    = 14'h0008,
        S_CG_REACH = 14'h0010,
        S_CG_RSQ   = 14'h0020,
        S_CG_GATE  = 14'h0040,
        S_T_SQX    = 14'h0080,
        S_T_SQY    = 14'h0100,
        S_T_SUM    = 14'h0200,
        S_TG_REACH = 14'h0400,
        S_TG_RSQ   = 14'h0800,
        S_TG_GATE  = 14'h1000,
        S_FIN      = 14'h2000
    } t_state;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '{load_in: 1'b0, mul_op: bts_pkg::MUL_NONE, sum_cand: 1'b0,
                    sum_tent: 1'b0, gate_conf: 1'b0, gate_tent: 1'b0, finish: 1'b0};
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_C_SQX;
                end
            end
            S_C_SQX: begin
                o_cmd.mul_op = bts_pkg::MUL_DX;
                n_state      = S_C_SQY;
            end
            S_C_SQY: begin
                o_cmd.mul_op = bts_pkg::MUL_DY;
                n_state      = S_C_SUM;
            end
            S_C_SUM: begin
                o_cmd.sum_cand = 1'b1;
                n_state        = i_status.last ? S_CG_REACH : S_IDLE;
            end
            S_CG_REACH: begin
                o_cmd.mul_op = bts_pkg::MUL_REACH;
                n_state      = S_CG_RSQ;
            end
            S_CG_RSQ: begin
                o_cmd.mul_op = bts_pkg::MUL_RSQ;
                n_state      = S_CG_GATE;
            end
            S_CG_GATE: begin
                o_cmd.gate_conf = 1'b1;
                n_state         = i_status.pass ? S_FIN : S_T_SQX;
            end
            S_T_SQX: begin
                o_cmd.mul_op = bts_pkg::MUL_DX;
                n_state      = S_T_SQY;
            end
            S_T_SQY: begin
                o_cmd.mul_op = bts_pkg::MUL_DY;
                n_state      = S_T_SUM;
            end
            S_T_SUM: begin
                o_cmd.sum_tent = 1'b1;
                n_state        = S_TG_REACH;
            end
            S_TG_REACH: begin
                o_cmd.mul_op = bts_pkg::MUL_REACH;
                n_state      = S_TG_RSQ;
            end
            S_TG_RSQ: begin
                o_cmd.mul_op = bts_pkg::MUL_RSQ;
                n_state      = S_TG_GATE;
            end
            S_TG_GATE: begin
                o_cmd.gate_tent = 1'b1;
                n_state         = S_FIN;
            end
            S_FIN: begin
                // Wait here until the result register can take the new item.
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/bts_dp.sv =====
`timescale 1ns / 1ps

module bts_dp #(
    parameter int COORD_BITS = bts_pkg::COORD_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [bts_pkg::STEP_W-1:0]           i_cfg_wdata,
    input  bts_pkg::t_cmd                        i_cmd,
    input  logic [bts_pkg::CYCLE_W-1:0]          i_cyc,
    input  logic signed [COORD_BITS-1:0]         i_cx,
    input  logic signed [COORD_BITS-1:0]         i_cy,
    input  logic [bts_pkg::HEIGHT_W-1:0]         i_ch,
    input  logic                                 i_last,
    input  logic                                 i_out_ready,
    output bts_pkg::t_status                     o_status,
    output logic                                 o_out_valid,
    output logic signed [COORD_BITS-1:0]         o_ball_x,
    output logic signed [COORD_BITS-1:0]         o_ball_y,
    output logic [bts_pkg::HEIGHT_W-1:0]         o_ball_h,
    output logic [bts_pkg::CASE_W-1:0]           o_case,
    output logic                                 o_switched
);

    localparam int SQ_W = 2 * COORD_BITS;
    localparam int D_W  = SQ_W + 1;

    // Configuration.
    logic [bts_pkg::STEP_W-1:0]          r_max_step;

    // Current item.
    logic [bts_pkg::CYCLE_W-1:0]         r_cyc;
    logic signed [COORD_BITS-1:0]        r_cx;
    logic signed [COORD_BITS-1:0]        r_cy;
    logic [bts_pkg::HEIGHT_W-1:0]        r_ch;
    logic                                r_last;

    // Arithmetic pipeline.
    logic [COORD_BITS-1:0]               r_adx;
    logic [COORD_BITS-1:0]               r_ady;
    logic [bts_pkg::PROD_W-1:0]          r_prod;
    logic [SQ_W-1:0]                     r_acc;
    logic [bts_pkg::EL_W-1:0]            r_el;
    logic                                r_el_ok;
    logic                                r_cap;
    logic [D_W-1:0]                      r_dt;

    // Frame best candidate.
    logic signed [COORD_BITS-1:0]        r_best_x;
    logic signed [COORD_BITS-1:0]        r_best_y;
    logic [bts_pkg::HEIGHT_W-1:0]        r_best_h;
    logic [D_W-1:0]                      r_best_d;
    logic                                r_have_best;

    // Confirmed and tentative tracks.
    logic signed [COORD_BITS-1:0]        r_conf_x;
    logic signed [COORD_BITS-1:0]        r_conf_y;
    logic [bts_pkg::HEIGHT_W-1:0]        r_conf_h;
    logic [bts_pkg::CYCLE_W-1:0]         r_conf_cycle;
    logic signed [bts_pkg::SCORE_W-1:0]  r_conf_score;
    logic signed [COORD_BITS-1:0]        r_tent_x;
    logic signed [COORD_BITS-1:0]        r_tent_y;
    logic [bts_pkg::HEIGHT_W-1:0]        r_tent_h;
    logic [bts_pkg::CYCLE_W-1:0]         r_tent_cycle;
    logic signed [bts_pkg::SCORE_W-1:0]  r_tent_score;
    logic [bts_pkg::CASE_W-1:0]          r_case;

    // Result register.
    logic                                r_out_valid;
    logic signed [COORD_BITS-1:0]        r_out_x;
    logic signed [COORD_BITS-1:0]        r_out_y;
    logic [bts_pkg::HEIGHT_W-1:0]        r_out_h;
    logic [bts_pkg::CASE_W-1:0]          r_out_case;
    logic                                r_out_sw;

    logic signed [COORD_BITS:0]          w_diff_x;
    logic signed [COORD_BITS:0]          w_diff_y;
    logic [COORD_BITS:0]                 w_neg_x;
    logic [COORD_BITS:0]                 w_neg_y;
    logic [COORD_BITS-1:0]               w_adx;
    logic [COORD_BITS-1:0]               w_ady;
    logic [bts_pkg::MUL_A_W-1:0]         w_mul_a;
    logic [bts_pkg::MUL_B_W-1:0]         w_mul_b;
    logic [bts_pkg::PROD_W-1:0]          w_prod;
    logic [D_W-1:0]                      w_sum;
    logic [bts_pkg::CYCLE_W-1:0]         w_el;
    logic [D_W-1:0]                      w_dsel;
    logic                                w_pass;
    logic                                w_promote;
    logic signed [bts_pkg::SCORE_W-1:0]  n_tent_score;
    logic signed [bts_pkg::SCORE_W-1:0]  n_conf_score;

    // Saturating score add.
    function automatic logic signed [bts_pkg::SCORE_W-1:0] sat_add(
        input logic signed [bts_pkg::SCORE_W-1:0] a,
        input logic signed [bts_pkg::SCORE_W-1:0] b
    );
        logic signed [bts_pkg::SCORE_W:0] s;
        s = {a[bts_pkg::SCORE_W-1], a} + {b[bts_pkg::SCORE_W-1], b};
        if (s[bts_pkg::SCORE_W] != s[bts_pkg::SCORE_W-1]) begin
            return s[bts_pkg::SCORE_W] ? bts_pkg::SCORE_MIN : bts_pkg::SCORE_MAX;
        end
        return s[bts_pkg::SCORE_W-1:0];
    endfunction

    // Absolute coordinate deltas: new detection against the confirmed track,
    // or the frame's best against the tentative track.
    always_comb begin
        if (i_cmd.load_in) begin
            w_diff_x = {i_cx[COORD_BITS-1], i_cx} - {r_conf_x[COORD_BITS-1], r_conf_x};
            w_diff_y = {i_cy[COORD_BITS-1], i_cy} - {r_conf_y[COORD_BITS-1], r_conf_y};
        end else begin
            w_diff_x = {r_best_x[COORD_BITS-1], r_best_x} - {r_tent_x[COORD_BITS-1], r_tent_x};
            w_diff_y = {r_best_y[COORD_BITS-1], r_best_y} - {r_tent_y[COORD_BITS-1], r_tent_y};
        end
        w_neg_x = -w_diff_x;
        w_neg_y = -w_diff_y;
        w_adx   = w_diff_x[COORD_BITS] ? w_neg_x[COORD_BITS-1:0] : w_diff_x[COORD_BITS-1:0];
        w_ady   = w_diff_y[COORD_BITS] ? w_neg_y[COORD_BITS-1:0] : w_diff_y[COORD_BITS-1:0];
    end

    // Shared multiplier operand selection.
    always_comb begin
        case (i_cmd.mul_op)
            bts_pkg::MUL_DX: begin
                w_mul_a = bts_pkg::MUL_A_W'(r_adx);
                w_mul_b = bts_pkg::MUL_B_W'(r_adx);
            end
            bts_pkg::MUL_DY: begin
                w_mul_a = bts_pkg::MUL_A_W'(r_ady);
                w_mul_b = bts_pkg::MUL_B_W'(r_ady);
            end
            bts_pkg::MUL_REACH: begin
                w_mul_a = bts_pkg::MUL_A_W'(r_el);
                w_mul_b = bts_pkg::MUL_B_W'(r_max_step);
            end
            bts_pkg::MUL_RSQ: begin
                w_mul_a = bts_pkg::MUL_A_W'(r_prod[bts_pkg::REACH_W-1:0]);
                w_mul_b = bts_pkg::MUL_B_W'(r_prod[bts_pkg::REACH_W-1:0]);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
        w_prod = bts_pkg::PROD_W'(w_mul_a) * bts_pkg::PROD_W'(w_mul_b);
    end

    // Distance sum, elapsed cycles and the gate decision.
    always_comb begin
        w_sum  = D_W'(r_acc) + D_W'(r_prod[SQ_W-1:0]);
        w_el   = r_cyc - (i_cmd.sum_tent ? r_tent_cycle : r_conf_cycle);
        w_dsel = i_cmd.gate_tent ? r_dt : r_best_d;
        w_pass = r_el_ok && (r_cap || (bts_pkg::PROD_W'(w_dsel) < r_prod));
    end

    // Score updates after the tentative gate, and the promotion test.
    always_comb begin
        n_tent_score = w_pass ? sat_add(r_tent_score, bts_pkg::SCORE_TENTH)
                              : bts_pkg::SCORE_TENTH;
        n_conf_score = sat_add(r_conf_score, -bts_pkg::SCORE_TWENTIETH);
        w_promote    = (r_conf_score < r_tent_score);
    end

    assign o_status = '{last: r_last, pass: w_pass,
                        out_free: (!r_out_valid || i_out_ready)};

    // Working registers that need no reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cyc  <= i_cyc;
            r_cx   <= i_cx;
            r_cy   <= i_cy;
            r_ch   <= i_ch;
            r_last <= i_last;
        end
        if (i_cmd.load_in || i_cmd.gate_conf) begin
            r_adx <= w_adx;
            r_ady <= w_ady;
        end
        if (i_cmd.mul_op != bts_pkg::MUL_NONE) begin
            r_prod <= w_prod;
        end
        if (i_cmd.mul_op == bts_pkg::MUL_DY) begin
            r_acc <= r_prod[SQ_W-1:0];
        end
        if (i_cmd.mul_op == bts_pkg::MUL_RSQ) begin
            r_cap <= (r_prod > bts_pkg::REACH_CAP);
        end
        if (i_cmd.sum_cand || i_cmd.sum_tent) begin
            r_el    <= w_el[bts_pkg::EL_W-1:0];
            r_el_ok <= (w_el != '0) && !w_el[bts_pkg::CYCLE_W-1];
        end
        if (i_cmd.sum_tent) begin
            r_dt <= w_sum;
        end
    end

    // Track state, best candidate and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_step   <= bts_pkg::STEP_RESET;
            r_best_x     <= '0;
            r_best_y     <= '0;
            r_best_h     <= '0;
            r_best_d     <= '0;
            r_have_best  <= 1'b0;
            r_conf_x     <= '0;
            r_conf_y     <= '0;
            r_conf_h     <= '0;
            r_conf_cycle <= '0;
            r_conf_score <= '0;
            r_tent_x     <= '0;
            r_tent_y     <= '0;
            r_tent_h     <= '0;
            r_tent_cycle <= '0;
            r_tent_score <= '0;
            r_case       <= bts_pkg::CASE_CONF;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_step <= i_cfg_wdata;
            end
            if (r_out_valid && i_out_ready && !i_cmd.finish) begin
                r_out_valid <= 1'b0;
            end

            // Keep the nearest detection; the first of a frame is always taken.
            if (i_cmd.sum_cand && (!r_have_best || (w_sum < r_best_d))) begin
                r_best_x    <= r_cx;
                r_best_y    <= r_cy;
                r_best_h    <= r_ch;
                r_best_d    <= w_sum;
                r_have_best <= 1'b1;
            end

            // Confirmed track gate: on a pass the track moves to the candidate.
            if (i_cmd.gate_conf && w_pass) begin
                r_conf_x     <= r_best_x;
                r_conf_y     <= r_best_y;
                r_conf_h     <= r_best_h;
                r_conf_cycle <= r_cyc;
                r_conf_score <= bts_pkg::SCORE_ONE;
                r_tent_score <= '0;
                r_case       <= bts_pkg::CASE_CONF;
            end

            // Tentative track gate: continue or restart the tentative track.
            if (i_cmd.gate_tent) begin
                r_tent_score <= n_tent_score;
                r_case       <= w_pass ? bts_pkg::CASE_TENT : bts_pkg::CASE_RESTART;
                r_tent_x     <= r_best_x;
                r_tent_y     <= r_best_y;
                r_tent_h     <= r_best_h;
                r_tent_cycle <= r_cyc;
                r_conf_score <= n_conf_score;
            end

            // End of frame: promotion, result item and best-candidate clear.
            if (i_cmd.finish) begin
                if (w_promote) begin
                    r_conf_x     <= r_tent_x;
                    r_conf_y     <= r_tent_y;
                    r_conf_h     <= r_tent_h;
                    r_conf_cycle <= r_tent_cycle;
                    r_conf_score <= r_tent_score;
                    r_tent_score <= '0;
                end
                r_out_valid <= 1'b1;
                r_have_best <= 1'b0;
                r_best_d    <= '0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_x    <= w_promote ? r_tent_x : r_conf_x;
            r_out_y    <= w_promote ? r_tent_y : r_conf_y;
            r_out_h    <= w_promote ? r_tent_h : r_conf_h;
            r_out_case <= r_case;
            r_out_sw   <= w_promote;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_ball_x    = r_out_x;
    assign o_ball_y    = r_out_y;
    assign o_ball_h    = r_out_h;
    assign o_case      = r_out_case;
    assign o_switched  = r_out_sw;

endmodule
